### src/smm_pkg.sv
package smm_pkg;

  // Store geometry
  localparam int MAX_DIM = 16;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 40;
  localparam int SIZE_W  = 5;

  // Largest size in use: the smaller of the store edge and the field span
  localparam int FIELD_SPAN = 1 << POS_W;
  localparam int SIZE_CAP   = (MAX_DIM < FIELD_SPAN) ? MAX_DIM : FIELD_SPAN;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // Command codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD_FIRST  = 2'd0;
  localparam op_t OP_LOAD_SECOND = 2'd1;
  localparam op_t OP_COMPUTE     = 2'd2;

  typedef struct packed {
    op_t                      op;
    logic [POS_W-1:0]         row_index;
    logic [POS_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [ACC_W-1:0] product_value;
    logic                    last;
  } result_t;

endpackage

### src/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/square_matrix_multiply.sv
// Square matrix multiplier, one product row per compute command.
// Command channel: cmd is taken at a rising edge with start high and busy
// low. Load commands (op load first / load second) write one Q8.8 element of
// the first or second matrix at row_index, col_index and give no result.
// A compute command names a result row and produces that row
// of the product, one word per column in column order, last set on the final
// column. A row index not below the size in use gives no result.
// Configuration: cfg_wr_en writes matrix_size from cfg_wr_data; sizes above
// 16 are used as 16. Write it only while busy is low.
// Results: result is valid for exactly one cycle while strobe is high; the
// receiver cannot stall the block.
// Timing: a compute command keeps busy high while it steps through the row
// and until the pipeline has drained; no new command is taken before then.
// A single shared multiply-accumulate reads both element memories once per
// cycle. The word of each column passes from the element memories through
// the product register and the accumulator into the result register.
// Reset: busy and strobe clear and matrix_size returns to 16; the element
// memories keep no reset value and must be written before they are read.
module square_matrix_multiply (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  smm_pkg::cmd_t                   cmd,
  input  logic                            cfg_wr_en,
  input  logic [smm_pkg::SIZE_W-1:0]      cfg_wr_data,
  output logic                            strobe,
  output smm_pkg::result_t                result
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [smm_pkg::SIZE_W-1:0] matrix_size;
  logic [smm_pkg::SIZE_W-1:0] size_used;
  logic [smm_pkg::IDX_W-1:0]  size_m1;

  logic accept;
  logic wr_first, wr_second, in_store, row_ok;

  logic [smm_pkg::POS_W-1:0]  row;
  logic [smm_pkg::IDX_W-1:0]  j_cnt, k_cnt;
  logic                       k_end, j_end;

  logic [smm_pkg::ADDR_W-1:0] wr_addr, rd_addr_first, rd_addr_second;
  logic [smm_pkg::ELEM_W-1:0] first_data, second_data;

  // Pipeline control: s1 = memory data, s2 = product register
  logic                       v1, v2;
  logic                       fk1, fk2, lk1, lk2;
  logic [smm_pkg::IDX_W-1:0]  j1, j2;
  logic signed [smm_pkg::PROD_W-1:0] prod;
  logic signed [smm_pkg::ACC_W-1:0]  acc, sum;

  // Clamp the size register to the store edge
  always_comb begin
    if (matrix_size > smm_pkg::SIZE_W'(smm_pkg::SIZE_CAP)) begin
      size_used = smm_pkg::SIZE_W'(smm_pkg::SIZE_CAP);
    end else begin
      size_used = matrix_size;
    end
  end
  assign size_m1 = smm_pkg::IDX_W'(size_used - smm_pkg::SIZE_W'(1));

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Decode load commands; drop writes outside the store
  assign in_store  = ({1'b0, cmd.row_index} < (smm_pkg::POS_W + 1)'(smm_pkg::MAX_DIM)) &&
                     ({1'b0, cmd.col_index} < (smm_pkg::POS_W + 1)'(smm_pkg::MAX_DIM));
  assign wr_first  = accept && (cmd.op == smm_pkg::OP_LOAD_FIRST) && in_store;
  assign wr_second = accept && (cmd.op == smm_pkg::OP_LOAD_SECOND) && in_store;
  assign row_ok    = {1'b0, cmd.row_index} < size_used;

  assign wr_addr = {cmd.row_index[smm_pkg::IDX_W-1:0], cmd.col_index[smm_pkg::IDX_W-1:0]};

  // Read first[row][k] and second[k][j]
  assign rd_addr_first  = {row[smm_pkg::IDX_W-1:0], k_cnt};
  assign rd_addr_second = {k_cnt, j_cnt};

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(smm_pkg::DEPTH)) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (wr_addr),
    .wr_data (cmd.element_value),
    .rd_addr (rd_addr_first),
    .rd_data (first_data)
  );

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(smm_pkg::DEPTH)) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (wr_addr),
    .wr_data (cmd.element_value),
    .rd_addr (rd_addr_second),
    .rd_data (second_data)
  );

  assign k_end = (k_cnt == size_m1);
  assign j_end = (j_cnt == size_m1);

  // Sequence the row: issue, then drain the pipeline
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd.op == smm_pkg::OP_COMPUTE) && row_ok) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_end && j_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      matrix_size <= smm_pkg::SIZE_RESET;
      v1          <= 1'b0;
      v2          <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state  <= state_next;
      if (cfg_wr_en) begin
        matrix_size <= cfg_wr_data;
      end
      v1     <= (state == ST_RUN);
      v2     <= v1;
      strobe <= v2 && lk2;
    end
  end

  // Hold the row and advance the column and k counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      row   <= cmd.row_index;
      j_cnt <= '0;
      k_cnt <= '0;
    end else if (state == ST_RUN) begin
      if (k_end) begin
        k_cnt <= '0;
        j_cnt <= j_cnt + smm_pkg::IDX_W'(1);
      end else begin
        k_cnt <= k_cnt + smm_pkg::IDX_W'(1);
      end
    end
  end

  // Carry tags alongside the data
  always_ff @(posedge clk) begin
    fk1  <= (k_cnt == '0);
    lk1  <= k_end;
    j1   <= j_cnt;
    fk2  <= fk1;
    lk2  <= lk1;
    j2   <= j1;
    prod <= $signed(first_data) * $signed(second_data);
  end

  // Accumulate, restarting at each column
  assign sum = (fk2 ? smm_pkg::ACC_W'(0) : acc) + smm_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= sum;
    end
    if (v2 && lk2) begin
      result.out_row       <= row;
      result.out_col       <= smm_pkg::POS_W'(j2);
      result.product_value <= sum;
      result.last          <= (j2 == size_m1);
    end
  end

endmodule
